// File: rtl/led_pulse_byte_sender_handshake_defines.svh
// assertion macros for the led pulse byte sender
// used by modules that check their own control logic; no other dependencies
`ifndef LED_PULSE_BYTE_SENDER_HANDSHAKE_DEFINES_SVH
`define LED_PULSE_BYTE_SENDER_HANDSHAKE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define LPBS_ASSERT_NOW(label, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |-> (rhs)) \
		else $error("lpbs same-cycle check failed");

// next-cycle implication, clocked on clk, off during reset
`define LPBS_ASSERT_NEXT(label, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |=> (rhs)) \
		else $error("lpbs next-cycle check failed");

`endif

// File: rtl/lpbs_pkg.sv
// shared types, constants and reply table for the led pulse byte sender
// no dependencies
package lpbs_pkg;

	localparam logic [20:0] HOLD_MAX     = 21'h1FFFFF;
	localparam logic [7:0]  CHAR_STOP    = 8'h55;
	localparam logic [7:0]  CHAR_QUERY   = 8'h3F;
	localparam logic [9:0]  ON_RESET     = 10'd35;
	localparam logic [9:0]  SLOT_RESET   = 10'd489;
	localparam logic [20:0] HOLD_RESET   = 21'd1000000;
	localparam logic [3:0]  SLOT_COUNT   = 4'd9;

	typedef enum logic [1:0] {
		REG_ON   = 2'd0,
		REG_SLOT = 2'd1,
		REG_HOLD = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [9:0]  on_ticks;
		logic [9:0]  slot_ticks;
		logic [20:0] hold_ticks;
	} cfg_t;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_REJECT = 2'd1,
		CMD_ECHO   = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic       led;
		logic       busy;
		logic [7:0] data;
	} cmd_t;

	typedef enum logic {
		BK_PASS  = 1'b0,
		BK_REPLY = 1'b1
	} back_state_t;

	function automatic logic [7:0] reply_byte(input logic [4:0] idx);
		logic [7:0] b;
		unique case (idx)
			5'd0:  b = 8'h31;
			5'd1:  b = 8'h32;
			5'd2:  b = 8'h36;
			5'd3:  b = 8'h0D;
			5'd4:  b = 8'h20;
			5'd5:  b = 8'h4D;
			5'd6:  b = 8'h37;
			5'd7:  b = 8'h36;
			5'd8:  b = 8'h34;
			5'd9:  b = 8'h20;
			5'd10: b = 8'h72;
			5'd11: b = 8'h65;
			5'd12: b = 8'h76;
			5'd13: b = 8'h20;
			5'd14: b = 8'h37;
			5'd15: b = 8'h36;
			5'd16: b = 8'h34;
			5'd17: b = 8'h30;
			5'd18: b = 8'h30;
			5'd19: b = 8'h32;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/led_pulse_byte_sender_handshake.sv
// led pulse byte sender: stream in, stream out, apb register port
// top level, instantiates lpbs_front, lpbs_fifo and lpbs_back; uses lpbs_pkg
//
// slave stream: one word per tick (s_tuser = 0) or host byte (s_tuser = 1, byte in s_tdata)
// master stream: one word per tick, rejected byte or echo; a '?' with the stop
// flag clear is followed by REPLY_LENGTH identity words, m_tlast on the final one
// a tick word carries the led level, an echo or reply word has m_tuser (tx_valid) set
// apb: on_ticks at 0x0, slot_ticks at 0x4, hold_ticks at 0x8, pready always high
// a word accepted on the slave side passes through the command queue and the output register
// throughput: one input word per cycle while the master side takes one word
// per cycle; a '?' reply fills the output register with the echo word, then REPLY_LENGTH reply words
// the front end runs ahead of the output by the two-entry command queue;
// s_tready drops only when that queue is full
// reset: led sequence idle, stop flag clear, hold counter zero, queue empty,
// registers at on_ticks 35, slot_ticks 489, hold_ticks 1000000
// a stalled master holds its word; the front end keeps accepting until the queue fills
module led_pulse_byte_sender_handshake #(
	parameter int REPLY_LENGTH = 21
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // led, tx_byte[7:0], rejected, busy_res, zero pad
	output logic        m_tuser,   // tx_valid
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lpbs_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_sel;
	logic     cfg_wr;

	cmd_t     push_data;
	cmd_t     pop_data;
	logic     push;
	logic     pop;
	logic     full;
	logic     not_empty;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_ticks   <= ON_RESET;
			cfg_q.slot_ticks <= SLOT_RESET;
			cfg_q.hold_ticks <= HOLD_RESET;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_ON:   cfg_q.on_ticks   <= pwdata[9:0];
				REG_SLOT: cfg_q.slot_ticks <= pwdata[9:0];
				REG_HOLD: cfg_q.hold_ticks <= pwdata[20:0];
				default:  cfg_q.on_ticks   <= cfg_q.on_ticks;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_ON:   prdata = {22'd0, cfg_q.on_ticks};
			REG_SLOT: prdata = {22'd0, cfg_q.slot_ticks};
			REG_HOLD: prdata = {11'd0, cfg_q.hold_ticks};
			default:  prdata = 32'd0;
		endcase
	end

	lpbs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_data   (push_data),
		.q_push   (push),
		.q_full   (full)
	);

	lpbs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (pop_data)
	);

	lpbs_back #(
		.REPLY_LENGTH (REPLY_LENGTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (not_empty),
		.q_data   (pop_data),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// File: rtl/lpbs_front.sv
// front end: accepts ticks and host bytes, keeps slot, hold and stop state
// depends on lpbs_pkg; pushes one command per word into the queue
module lpbs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  lpbs_pkg::cfg_t    cfg,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tuser,
	output lpbs_pkg::cmd_t    q_data,
	output logic              q_push,
	input  logic              q_full
);
	import lpbs_pkg::*;

	logic [7:0]  shift_q;
	logic [3:0]  slot_q;
	logic [9:0]  tick_q;
	logic        sending_q;
	logic        stop_q;
	logic [20:0] hold_q;

	logic [7:0]  shift_d;
	logic [3:0]  slot_d;
	logic [9:0]  tick_d;
	logic        sending_d;
	logic        stop_d;
	logic [20:0] hold_d;

	logic        accept;
	logic [10:0] tick_inc;
	logic [3:0]  slot_inc;
	logic [2:0]  bit_sel;
	logic        pulse;
	logic [20:0] hold_inc;

	assign s_tready = ~q_full;
	assign accept   = s_tvalid & ~q_full;
	assign q_push   = accept;

	assign tick_inc = {1'b0, tick_q} + 11'd1;
	assign slot_inc = slot_q + 4'd1;
	assign bit_sel  = slot_q[2:0] - 3'd1;
	assign pulse    = (slot_q == 4'd0) ? 1'b1 : ~shift_q[bit_sel];
	assign hold_inc = (hold_q != HOLD_MAX) ? hold_q + 21'd1 : hold_q;

	always_comb begin
		shift_d       = shift_q;
		slot_d        = slot_q;
		tick_d        = tick_q;
		sending_d     = sending_q;
		stop_d        = stop_q;
		hold_d        = hold_q;
		q_data.kind   = CMD_TICK;
		q_data.led    = 1'b0;
		q_data.busy   = 1'b1;
		q_data.data   = s_tdata;
		if (!s_tuser) begin
			q_data.busy = sending_q;
			if (sending_q) begin
				q_data.led = pulse & (tick_q < cfg.on_ticks);
				if (tick_inc >= {1'b0, cfg.slot_ticks}) begin
					tick_d = 10'd0;
					if (slot_inc >= SLOT_COUNT) begin
						slot_d    = 4'd0;
						sending_d = 1'b0;
					end else begin
						slot_d = slot_inc;
					end
				end else begin
					tick_d = tick_inc[9:0];
				end
			end
			hold_d = hold_inc;
			if (hold_inc > cfg.hold_ticks) begin
				stop_d = 1'b0;
			end
		end else if (sending_q) begin
			q_data.kind = CMD_REJECT;
		end else begin
			sending_d = 1'b1;
			shift_d   = s_tdata;
			slot_d    = 4'd0;
			tick_d    = 10'd0;
			if (s_tdata == CHAR_QUERY) begin
				q_data.kind = stop_q ? CMD_ECHO : CMD_QUERY;
			end else begin
				q_data.kind = CMD_ECHO;
				hold_d      = 21'd0;
				if (s_tdata == CHAR_STOP) begin
					stop_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q   <= 8'd0;
			slot_q    <= 4'd0;
			tick_q    <= 10'd0;
			sending_q <= 1'b0;
			stop_q    <= 1'b0;
			hold_q    <= 21'd0;
		end else if (accept) begin
			shift_q   <= shift_d;
			slot_q    <= slot_d;
			tick_q    <= tick_d;
			sending_q <= sending_d;
			stop_q    <= stop_d;
			hold_q    <= hold_d;
		end
	end

endmodule

// File: rtl/lpbs_fifo.sv
// two-entry command queue between front end and back end
// depends on lpbs_pkg for the command type
module lpbs_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lpbs_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output lpbs_pkg::cmd_t pop_data
);
	import lpbs_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/lpbs_back.sv
// back end: turns queued commands into output words, streams the identity reply
// depends on lpbs_pkg and the assertion macro header
module lpbs_back #(
	parameter int REPLY_LENGTH = 21
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  lpbs_pkg::cmd_t q_data,
	output logic           q_pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [15:0]    m_tdata,   // led, tx_byte[7:0], rejected, busy_res, zero pad
	output logic           m_tuser,   // tx_valid
	output logic           m_tlast
);
	import lpbs_pkg::*;

	`include "led_pulse_byte_sender_handshake_defines.svh"

	localparam int IW = $clog2(REPLY_LENGTH + 1);

	back_state_t   state_q;
	back_state_t   state_d;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] idx_d;
	logic          idx_last;
	logic          load;

	logic          valid_q;
	logic          led_q;
	logic          txv_q;
	logic [7:0]    byte_q;
	logic          last_q;
	logic          rej_q;
	logic          busy_q;

	logic          led_d;
	logic          txv_d;
	logic [7:0]    byte_d;
	logic          last_d;
	logic          rej_d;
	logic          emit;

	assign load     = ~valid_q | m_tready;
	assign idx_last = (idx_q == IW'(REPLY_LENGTH - 1));

	// next state
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		unique case (state_q)
			BK_PASS: begin
				if (load && q_valid && q_data.kind == CMD_QUERY) begin
					state_d = BK_REPLY;
					idx_d   = '0;
				end
			end
			BK_REPLY: begin
				if (load) begin
					idx_d = idx_q + IW'(1);
					if (idx_last) begin
						state_d = BK_PASS;
					end
				end
			end
			default: state_d = BK_PASS;
		endcase
	end

	// outputs
	always_comb begin
		q_pop  = 1'b0;
		emit   = 1'b0;
		led_d  = 1'b0;
		txv_d  = 1'b0;
		byte_d = 8'd0;
		last_d = 1'b1;
		rej_d  = 1'b0;
		unique case (state_q)
			BK_PASS: begin
				if (load && q_valid) begin
					q_pop = 1'b1;
					emit  = 1'b1;
					unique case (q_data.kind)
						CMD_TICK:   led_d = q_data.led;
						CMD_REJECT: rej_d = 1'b1;
						CMD_ECHO: begin
							txv_d  = 1'b1;
							byte_d = q_data.data;
						end
						CMD_QUERY: begin
							txv_d  = 1'b1;
							byte_d = q_data.data;
							last_d = 1'b0;
						end
						default: rej_d = 1'b0;
					endcase
				end
			end
			BK_REPLY: begin
				if (load) begin
					emit   = 1'b1;
					txv_d  = 1'b1;
					byte_d = reply_byte(5'(idx_q));
					last_d = idx_last;
				end
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_PASS;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (load) begin
				valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			led_q  <= led_d;
			txv_q  <= txv_d;
			byte_q <= byte_d;
			last_q <= last_d;
			rej_q  <= rej_d;
			busy_q <= (state_q == BK_REPLY) ? 1'b1 : q_data.busy;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {5'd0, busy_q, rej_q, byte_q, led_q};
	assign m_tuser  = txv_q;
	assign m_tlast  = last_q;

	`LPBS_ASSERT_NOW(a_reply_has_word, state_q == BK_REPLY, valid_q)
	`LPBS_ASSERT_NOW(a_pop_only_in_pass, q_pop, state_q == BK_PASS)
	`LPBS_ASSERT_NOW(a_open_word_is_tx, valid_q && !last_q, txv_q && busy_q)
	`LPBS_ASSERT_NEXT(a_query_starts_reply, q_pop && q_data.kind == CMD_QUERY,
		state_q == BK_REPLY && idx_q == '0)

endmodule
